// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define RFC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rfc check failed");

// property checked on every rising edge, reset included
`define RFC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rfc check failed");

`endif

// File: design/rfc_pkg.sv
// shared types, constants and crc function for the response frame checker
package rfc_pkg;

   localparam int SAMPLE_COUNT  = 1024;
   localparam int HEADER_WORDS  = 8;
   localparam int WORD_WIDTH    = 16;
   localparam int CRC_WIDTH     = 16;
   localparam int COUNT_WIDTH   = 32;
   localparam int FLAGS_WIDTH   = 6;
   localparam int POS_WIDTH     = 11;
   localparam int HDR_IDX_WIDTH = $clog2(HEADER_WORDS);
   localparam int RSP_TDATA_WIDTH = WORD_WIDTH + 2 + FLAGS_WIDTH + WORD_WIDTH + 4 * COUNT_WIDTH;

   localparam logic [POS_WIDTH-1:0] POS_HEADER_END  = POS_WIDTH'(HEADER_WORDS);
   localparam logic [POS_WIDTH-1:0] POS_LAST_STATUS = POS_WIDTH'(HEADER_WORDS);
   localparam logic [POS_WIDTH-1:0] POS_LAST_READ   = POS_WIDTH'(HEADER_WORDS + SAMPLE_COUNT);

   // header word slots
   localparam logic [HDR_IDX_WIDTH-1:0] HDR_SYNC     = HDR_IDX_WIDTH'(0);
   localparam logic [HDR_IDX_WIDTH-1:0] HDR_VERSION  = HDR_IDX_WIDTH'(1);
   localparam logic [HDR_IDX_WIDTH-1:0] HDR_FLAGS    = HDR_IDX_WIDTH'(2);
   localparam logic [HDR_IDX_WIDTH-1:0] HDR_FRAME_ID = HDR_IDX_WIDTH'(3);
   localparam logic [HDR_IDX_WIDTH-1:0] HDR_COUNT    = HDR_IDX_WIDTH'(5);
   localparam logic [HDR_IDX_WIDTH-1:0] HDR_OTR_LOW  = HDR_IDX_WIDTH'(6);
   localparam logic [HDR_IDX_WIDTH-1:0] HDR_OTR_HIGH = HDR_IDX_WIDTH'(7);

   localparam logic [WORD_WIDTH-1:0] SYNC_WORD    = 16'h5AA5;
   localparam logic [WORD_WIDTH-1:0] VERSION_WORD = 16'h0001;
   localparam logic [WORD_WIDTH-1:0] COUNT_WORD   = WORD_WIDTH'(SAMPLE_COUNT);
   localparam logic [CRC_WIDTH-1:0]  CRC_POLY     = 16'h1021;
   localparam logic [CRC_WIDTH-1:0]  CRC_INIT     = 16'hFFFF;

   typedef enum logic [1:0] {
      VERDICT_OK       = 2'd0,
      VERDICT_PROTOCOL = 2'd1,
      VERDICT_CRC      = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] word;
      logic                  first;
   } item_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] sample;
      logic                         sample_valid;
      logic                         frame_done;
      verdict_type                  verdict;
      logic [FLAGS_WIDTH-1:0]       status_flags;
      logic [WORD_WIDTH-1:0]        frame_number;
      logic [COUNT_WIDTH-1:0]       overrange_total;
      logic [COUNT_WIDTH-1:0]       good_total;
      logic [COUNT_WIDTH-1:0]       protocol_error_total;
      logic [COUNT_WIDTH-1:0]       crc_error_total;
   } result_type;

   typedef logic [CRC_WIDTH-1:0][CRC_WIDTH-1:0] crc_table_type;

   // a word-wide update depends only on crc ^ data, so it is linear in that
   // value: column i is the register after shifting in sixteen zero bits
   // from a one in bit i
   function automatic crc_table_type build_crc_columns();
      crc_table_type        columns;
      logic [CRC_WIDTH-1:0] c;
      for (int i = 0; i < CRC_WIDTH; i++) begin
         c = CRC_WIDTH'(1) << i;
         for (int k = 0; k < WORD_WIDTH; k++) begin
            if (c[CRC_WIDTH-1]) begin
               c = (c << 1) ^ CRC_POLY;
            end else begin
               c = c << 1;
            end
         end
         columns[i] = c;
      end
      return columns;
   endfunction

   localparam crc_table_type CRC_COLUMNS = build_crc_columns();

   function automatic logic [CRC_WIDTH-1:0] crc_update(input logic [CRC_WIDTH-1:0] crc,
                                                       input logic [WORD_WIDTH-1:0] data);
      logic [CRC_WIDTH-1:0] x;
      logic [CRC_WIDTH-1:0] acc;
      x   = crc ^ data;
      acc = '0;
      for (int i = 0; i < CRC_WIDTH; i++) begin
         if (x[i]) begin
            acc = acc ^ CRC_COLUMNS[i];
         end
      end
      return acc;
   endfunction

endpackage

// File: design/response_frame_checker_core.sv
// top level of the framed response checker: word stream in, sample and verdict stream out
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tdata: word; tuser: first
//  rsp      out        rsp_tvalid/rsp_tready  tdata: result fields; tuser: sample_valid;
//                                             tlast: frame_done
//  csr      in         csr_valid/csr_ready    csr_data: frame_mode
//
// one item per cycle sustained while rsp_tready stays high; the crc update is one xor network per word
// rsp_tvalid rises once an accepted item has passed the input register, then the result register
// synchronous reset restores all frame state and counters at once, no clearing pass
// req_tready drops only while both registers are full and rsp_tready is low
// csr writes are always taken and should land only while no item is in flight
module response_frame_checker_core import rfc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: [15:0] word
   input  logic [WORD_WIDTH-1:0]      req_tdata,
   // req_tuser: [0] first
   input  logic [0:0]                 req_tuser,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // rsp_tdata: [15:0] sample, [17:16] verdict, [23:18] status_flags,
   // [39:24] frame_number, [71:40] overrange_total, [103:72] good_total,
   // [135:104] protocol_error_total, [167:136] crc_error_total
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // rsp_tuser: [0] sample_valid
   output logic [0:0]                 rsp_tuser,
   output logic                       rsp_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_data,
   input  logic                       csr_valid,
   output logic                       csr_ready
);

   item_type   req_item;
   item_type   held_item;
   logic       held_valid;
   logic       can_load;
   logic       advance;
   result_type result_next;
   result_type rsp_result;

   assign req_item.word  = req_tdata;
   assign req_item.first = req_tuser[0];

   // an item moves to the result register whenever there is room for it
   assign advance   = held_valid && can_load;
   assign csr_ready = 1'b1;

   rfc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_item    (req_item),
      .advance    (advance),
      .in_ready   (req_tready),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   rfc_frame_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (held_item),
      .mode_write (csr_valid && csr_ready),
      .mode_data  (csr_data),
      .result     (result_next)
   );

   rfc_output_stage u_output (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .result_next (result_next),
      .out_ready   (rsp_tready),
      .can_load    (can_load),
      .out_valid   (rsp_tvalid),
      .out_result  (rsp_result)
   );

   // sample in the lowest bits, counters on top
   assign rsp_tdata = {rsp_result.crc_error_total,
                       rsp_result.protocol_error_total,
                       rsp_result.good_total,
                       rsp_result.overrange_total,
                       rsp_result.frame_number,
                       rsp_result.status_flags,
                       logic'(rsp_result.verdict[1]), logic'(rsp_result.verdict[0]),
                       rsp_result.sample};
   assign rsp_tuser = rsp_result.sample_valid;
   assign rsp_tlast = rsp_result.frame_done;

endmodule

// File: design/rfc_input_stage.sv
// input register holding one accepted item
module rfc_input_stage import rfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   input  logic     advance,
   output logic     in_ready,
   output logic     held_valid,
   output item_type held_item
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// File: design/rfc_frame_engine.sv
// frame tracking, header checks, crc and counters for one word per cycle while advance is high
module rfc_frame_engine import rfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  logic       mode_write,
   input  logic       mode_data,
   output result_type result
);

   logic                   frame_mode_ff;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [CRC_WIDTH-1:0]   crc_ff, crc_in;
   logic                   mismatch_ff, mismatch_in;
   logic [FLAGS_WIDTH-1:0] pend_flags_ff, pend_flags_in;
   logic [WORD_WIDTH-1:0]  pend_id_ff, pend_id_in;
   logic [COUNT_WIDTH-1:0] pend_otr_ff, pend_otr_in;
   logic [COUNT_WIDTH-1:0] good_ff, good_in;
   logic [COUNT_WIDTH-1:0] proto_ff, proto_in;
   logic [COUNT_WIDTH-1:0] crcerr_ff, crcerr_in;
   logic [FLAGS_WIDTH-1:0] lat_flags_ff, lat_flags_in;
   logic [WORD_WIDTH-1:0]  lat_id_ff, lat_id_in;
   logic [COUNT_WIDTH-1:0] lat_otr_ff, lat_otr_in;

   logic [POS_WIDTH-1:0]   pos_eff;
   logic [CRC_WIDTH-1:0]   crc_eff;
   logic                   mismatch_eff;
   logic [POS_WIDTH-1:0]   last_pos;

   always_comb begin
      // a first mark restarts the frame
      pos_eff      = item.first ? '0 : pos_ff;
      crc_eff      = item.first ? CRC_INIT : crc_ff;
      mismatch_eff = item.first ? 1'b0 : mismatch_ff;
      last_pos     = frame_mode_ff ? POS_LAST_READ : POS_LAST_STATUS;

      pos_in        = pos_eff;
      crc_in        = crc_eff;
      mismatch_in   = mismatch_eff;
      pend_flags_in = pend_flags_ff;
      pend_id_in    = pend_id_ff;
      pend_otr_in   = pend_otr_ff;
      good_in       = good_ff;
      proto_in      = proto_ff;
      crcerr_in     = crcerr_ff;
      lat_flags_in  = lat_flags_ff;
      lat_id_in     = lat_id_ff;
      lat_otr_in    = lat_otr_ff;

      result.sample       = '0;
      result.sample_valid = 1'b0;
      result.frame_done   = 1'b0;
      result.verdict      = VERDICT_OK;

      if (pos_eff >= last_pos) begin
         // crc word: protocol errors win over crc errors
         result.frame_done = 1'b1;
         if (mismatch_eff) begin
            result.verdict = VERDICT_PROTOCOL;
            proto_in       = proto_ff + COUNT_WIDTH'(1);
         end else if (crc_eff != item.word) begin
            result.verdict = VERDICT_CRC;
            crcerr_in      = crcerr_ff + COUNT_WIDTH'(1);
         end else begin
            lat_id_in  = pend_id_ff;
            lat_otr_in = pend_otr_ff;
            if (frame_mode_ff) begin
               good_in = good_ff + COUNT_WIDTH'(1);
            end else begin
               lat_flags_in = pend_flags_ff;
            end
         end
         pos_in      = '0;
         crc_in      = CRC_INIT;
         mismatch_in = 1'b0;
      end else begin
         crc_in = crc_update(crc_eff, item.word);
         pos_in = pos_eff + POS_WIDTH'(1);
         if (pos_eff >= POS_HEADER_END) begin
            result.sample       = signed'(item.word);
            result.sample_valid = 1'b1;
         end else begin
            case (pos_eff[HDR_IDX_WIDTH-1:0])
               HDR_SYNC: begin
                  if (item.word != SYNC_WORD) mismatch_in = 1'b1;
               end
               HDR_VERSION: begin
                  if (item.word != VERSION_WORD) mismatch_in = 1'b1;
               end
               HDR_FLAGS: begin
                  pend_flags_in = {item.word[6], item.word[4:0]};
               end
               HDR_FRAME_ID: begin
                  pend_id_in = item.word;
               end
               HDR_COUNT: begin
                  if (frame_mode_ff && item.word != COUNT_WORD) mismatch_in = 1'b1;
               end
               HDR_OTR_LOW: begin
                  pend_otr_in = {pend_otr_ff[COUNT_WIDTH-1:WORD_WIDTH], item.word};
               end
               HDR_OTR_HIGH: begin
                  pend_otr_in = {item.word, pend_otr_ff[WORD_WIDTH-1:0]};
               end
               default: begin
               end
            endcase
         end
      end

      result.status_flags         = lat_flags_in;
      result.frame_number         = lat_id_in;
      result.overrange_total      = lat_otr_in;
      result.good_total           = good_in;
      result.protocol_error_total = proto_in;
      result.crc_error_total      = crcerr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff <= 1'b0;
         pos_ff        <= '0;
         crc_ff        <= CRC_INIT;
         mismatch_ff   <= 1'b0;
         pend_flags_ff <= '0;
         pend_id_ff    <= '0;
         pend_otr_ff   <= '0;
         good_ff       <= '0;
         proto_ff      <= '0;
         crcerr_ff     <= '0;
         lat_flags_ff  <= '0;
         lat_id_ff     <= '0;
         lat_otr_ff    <= '0;
      end else begin
         if (mode_write) begin
            frame_mode_ff <= mode_data;
         end
         if (advance) begin
            pos_ff        <= pos_in;
            crc_ff        <= crc_in;
            mismatch_ff   <= mismatch_in;
            pend_flags_ff <= pend_flags_in;
            pend_id_ff    <= pend_id_in;
            pend_otr_ff   <= pend_otr_in;
            good_ff       <= good_in;
            proto_ff      <= proto_in;
            crcerr_ff     <= crcerr_in;
            lat_flags_ff  <= lat_flags_in;
            lat_id_ff     <= lat_id_in;
            lat_otr_ff    <= lat_otr_in;
         end
      end
   end

endmodule

// File: design/rfc_output_stage.sv
// result register toward the response channel
module rfc_output_stage import rfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result_next,
   input  logic       out_ready,
   output logic       can_load,
   output logic       out_valid,
   output result_type out_result
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result_next;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// File: design/rfc_checker.sv
// port-level checks for the response frame checker, bound to the top level
`include "assert_macros.svh"

module rfc_checker import rfc_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic [0:0]                 rsp_tuser,
   input logic                       rsp_tlast,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready
);

   `RFC_ASSERT(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `RFC_ASSERT_ALWAYS(rsp_reset_a, clock, reset |=> !rsp_tvalid)
   `RFC_ASSERT(done_not_sample_a, clock, reset, rsp_tvalid && rsp_tlast |-> !rsp_tuser[0])
   `RFC_ASSERT(verdict_idle_a, clock, reset, rsp_tvalid && !rsp_tlast |-> rsp_tdata[17:16] == 2'd0)
   `RFC_ASSERT(sample_zero_a, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[15:0] == 16'd0)

endmodule

bind response_frame_checker_core rfc_checker u_rfc_checker (.*);

// File: dv/testbench.sv
// self-checking testbench for the framed response checker: directed and random word streams vs a predictor
module testbench;
   import rfc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RX_HOLD_CYCLES = 400;
   localparam int RX_HOLD_AFTER  = 300;
   localparam int CSR_SETTLE     = 4;
   localparam int TAIL_CYCLES    = 8;
   localparam int MAX_REPORTS    = 40;
   localparam int PHASE_ITEMS    = 20;
   localparam int PHASE_COUNT    = 12;

   typedef enum int {FLAW_NONE, FLAW_SYNC, FLAW_VERSION, FLAW_COUNT, FLAW_CRC} frame_flaw_type;
   typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} header_fill_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic [WORD_WIDTH-1:0]      req_tdata = '0;
   logic [0:0]                 req_tuser = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic [0:0]                 rsp_tuser;
   logic                       rsp_tlast;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic                       csr_data = 1'b0;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;

   // msb-first word-wide crc step, bit by bit
   function automatic logic [CRC_WIDTH-1:0] crc16_ccitt_word(input logic [CRC_WIDTH-1:0] crc,
                                                             input logic [WORD_WIDTH-1:0] data);
      logic feedback;
      for (int k = 0; k < WORD_WIDTH; k++) begin
         feedback = data[WORD_WIDTH-1] ^ crc[CRC_WIDTH-1];
         crc = crc << 1;
         if (feedback) begin
            crc = crc ^ CRC_POLY;
         end
         data = data << 1;
      end
      return crc;
   endfunction

   class verdict_scoreboard;
      logic                   frame_mode;
      logic [POS_WIDTH-1:0]   word_pos;
      logic [CRC_WIDTH-1:0]   crc_acc;
      logic                   hdr_bad;
      logic [FLAGS_WIDTH-1:0] pend_flags;
      logic [WORD_WIDTH-1:0]  pend_id;
      logic [COUNT_WIDTH-1:0] pend_otr;
      logic [COUNT_WIDTH-1:0] good_cnt;
      logic [COUNT_WIDTH-1:0] proto_cnt;
      logic [COUNT_WIDTH-1:0] crc_cnt;
      logic [FLAGS_WIDTH-1:0] held_flags;
      logic [WORD_WIDTH-1:0]  held_id;
      logic [COUNT_WIDTH-1:0] held_otr;
      result_type             awaited_responses[$];
      int                     failures;

      function new();
         frame_mode = 1'b0;
         restart();
         pend_flags = '0;
         pend_id    = '0;
         pend_otr   = '0;
         good_cnt   = '0;
         proto_cnt  = '0;
         crc_cnt    = '0;
         held_flags = '0;
         held_id    = '0;
         held_otr   = '0;
         failures   = 0;
      endfunction

      function void restart();
         word_pos = '0;
         crc_acc  = CRC_INIT;
         hdr_bad  = 1'b0;
      endfunction

      function void set_mode(input logic m);
         frame_mode = m;
      endfunction

      function int outstanding();
         return awaited_responses.size();
      endfunction

      // one accepted word always yields exactly one response
      function void absorb_word(input logic [WORD_WIDTH-1:0] w, input logic fmark);
         result_type           r;
         logic [POS_WIDTH-1:0] frame_end;
         r = '0;
         frame_end = frame_mode ? POS_LAST_READ : POS_LAST_STATUS;
         if (fmark) begin
            restart();
         end
         if (word_pos >= frame_end) begin
            // crc word: protocol errors win over crc errors
            r.frame_done = 1'b1;
            if (hdr_bad) begin
               r.verdict = VERDICT_PROTOCOL;
               proto_cnt++;
            end else if (crc_acc != w) begin
               r.verdict = VERDICT_CRC;
               crc_cnt++;
            end else begin
               held_id  = pend_id;
               held_otr = pend_otr;
               if (frame_mode) begin
                  good_cnt++;
               end else begin
                  held_flags = pend_flags;
               end
            end
            restart();
         end else begin
            crc_acc = crc16_ccitt_word(crc_acc, w);
            if (word_pos >= POS_HEADER_END) begin
               r.sample       = w;
               r.sample_valid = 1'b1;
            end else begin
               case (word_pos[HDR_IDX_WIDTH-1:0])
                  HDR_SYNC: begin
                     if (w != SYNC_WORD) hdr_bad = 1'b1;
                  end
                  HDR_VERSION: begin
                     if (w != VERSION_WORD) hdr_bad = 1'b1;
                  end
                  HDR_FLAGS: begin
                     pend_flags = {w[6], w[4:0]};
                  end
                  HDR_FRAME_ID: begin
                     pend_id = w;
                  end
                  HDR_COUNT: begin
                     if (frame_mode && w != COUNT_WORD) hdr_bad = 1'b1;
                  end
                  HDR_OTR_LOW: begin
                     pend_otr[15:0] = w;
                  end
                  HDR_OTR_HIGH: begin
                     pend_otr[31:16] = w;
                  end
                  default: begin
                  end
               endcase
            end
            word_pos++;
         end
         r.status_flags         = held_flags;
         r.frame_number         = held_id;
         r.overrange_total      = held_otr;
         r.good_total           = good_cnt;
         r.protocol_error_total = proto_cnt;
         r.crc_error_total      = crc_cnt;
         awaited_responses.push_back(r);
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         failures++;
         if (failures <= MAX_REPORTS) begin
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
         end
      endtask

      task check_field(input string what, input logic [31:0] got, input logic [31:0] want);
         if (got !== want) begin
            report(what, got, want);
         end
      endtask

      task compare_response(input result_type got);
         result_type want;
         if (awaited_responses.size() == 0) begin
            report("response with no item pending", got.frame_done, 0);
            return;
         end
         want = awaited_responses.pop_front();
         check_field("sample", got.sample, want.sample);
         check_field("sample_valid", got.sample_valid, want.sample_valid);
         check_field("frame_done", got.frame_done, want.frame_done);
         check_field("verdict", got.verdict, want.verdict);
         check_field("status_flags", got.status_flags, want.status_flags);
         check_field("frame_number", got.frame_number, want.frame_number);
         check_field("overrange_total", got.overrange_total, want.overrange_total);
         check_field("good_total", got.good_total, want.good_total);
         check_field("protocol_error_total", got.protocol_error_total,
                     want.protocol_error_total);
         check_field("crc_error_total", got.crc_error_total, want.crc_error_total);
      endtask
   endclass

   verdict_scoreboard        board;
   int                       items_sent = 0;
   int                       idle_cycles = 0;
   logic                     frame_open = 1'b0;
   logic                     cur_mode = 1'b0;
   logic                     needs_close = 1'b0;
   logic [CRC_WIDTH-1:0]     open_crc = CRC_INIT;

   response_frame_checker_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic result_type capture_response();
      result_type r;
      r.sample               = rsp_tdata[15:0];
      r.verdict              = verdict_type'(rsp_tdata[17:16]);
      r.status_flags         = rsp_tdata[23:18];
      r.frame_number         = rsp_tdata[39:24];
      r.overrange_total      = rsp_tdata[71:40];
      r.good_total           = rsp_tdata[103:72];
      r.protocol_error_total = rsp_tdata[135:104];
      r.crc_error_total      = rsp_tdata[167:136];
      r.sample_valid         = rsp_tuser[0];
      r.frame_done           = rsp_tlast;
      return r;
   endfunction

   // handshakes sampled at the edge, before this edge's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.absorb_word(req_tdata, req_tuser[0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.compare_response(capture_response());
         end
      end
   end

   // ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, none at all when quiet
   function automatic int pick_gap(input bit quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit sender_quiet();
      return ((items_sent / 128) % 2) == 1;
   endfunction

   function automatic bit receiver_quiet();
      return ((items_sent / 128) % 4) >= 2;
   endfunction

   // receiver side, with one long hold-off so the block backs up
   initial begin : rx_side
      int gap;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && items_sent >= RX_HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap(receiver_quiet());
            if (gap == 0) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   function automatic logic [WORD_WIDTH-1:0] any_word();
      case ($urandom_range(0, 19))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [WORD_WIDTH-1:0] other_than(input logic [WORD_WIDTH-1:0] x);
      logic [WORD_WIDTH-1:0] w;
      w = any_word();
      if (w == x) w = ~x;
      return w;
   endfunction

   function automatic frame_flaw_type pick_flaw();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return FLAW_NONE;
      if (roll < 70) return FLAW_SYNC;
      if (roll < 80) return FLAW_VERSION;
      if (roll < 90) return FLAW_COUNT;
      return FLAW_CRC;
   endfunction

   // a sync word may go without its mark only where a frame starts anyway
   function automatic logic choose_mark();
      if (frame_open) return 1'b1;
      return ($urandom_range(0, 3) != 0);
   endfunction

   task automatic push_word(input logic [WORD_WIDTH-1:0] w, input logic fmark);
      int gap;
      gap = pick_gap(sender_quiet());
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= w;
      req_tuser  <= fmark;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic put_word(input logic [WORD_WIDTH-1:0] w, input logic fmark);
      open_crc = crc16_ccitt_word(open_crc, w);
      frame_open = 1'b1;
      push_word(w, fmark);
   endtask

   // sender stops and waits for every outstanding response
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   task automatic set_frame_mode(input logic m);
      drain();
      repeat (CSR_SETTLE) @(posedge clock);
      csr_data  <= m;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_mode(m);
      cur_mode = m;
   endtask

   task automatic send_header(input frame_flaw_type flaw, input int n_words,
                              input header_fill_type fill, input logic fmark);
      logic [WORD_WIDTH-1:0] w;
      open_crc = CRC_INIT;
      for (int i = 0; i < n_words; i++) begin
         case (fill)
            FILL_ONES:  w = '1;
            FILL_ZEROS: w = '0;
            default:    w = any_word();
         endcase
         if (i == HDR_SYNC) begin
            w = (flaw == FLAW_SYNC) ? other_than(SYNC_WORD) : SYNC_WORD;
         end else if (i == HDR_VERSION) begin
            w = (flaw == FLAW_VERSION) ? other_than(VERSION_WORD) : VERSION_WORD;
         end else if (i == HDR_COUNT) begin
            if (flaw == FLAW_COUNT) begin
               w = other_than(COUNT_WORD);
            end else if (cur_mode || (fill == FILL_RANDOM && $urandom_range(0, 1) == 1)) begin
               w = COUNT_WORD;
            end
         end
         put_word(w, (i == 0) ? fmark : 1'b0);
      end
   endtask

   task automatic send_samples(input int n);
      for (int i = 0; i < n; i++) begin
         put_word(any_word(), 1'b0);
      end
   endtask

   task automatic finish_frame(input bit corrupt);
      logic [WORD_WIDTH-1:0] w;
      w = open_crc;
      if (corrupt) w = w ^ WORD_WIDTH'($urandom_range(1, 16'hFFFF));
      push_word(w, 1'b0);
      frame_open = 1'b0;
   endtask

   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++) begin
         push_word(any_word(), $urandom_range(0, 9) == 0);
      end
      frame_open = 1'b1;
   endtask

   task automatic run_directed();
      set_frame_mode(1'b0);
      // sync without its mark right after reset, every header field but sync and version at all ones
      send_header(FLAW_NONE, 8, FILL_ONES, 1'b0);
      finish_frame(1'b0);
      // bad sync cut short by a new first mark, then a zero-filled frame with a bad crc
      send_header(FLAW_SYNC, 3, FILL_ZEROS, 1'b1);
      send_header(FLAW_NONE, 8, FILL_ZEROS, 1'b1);
      finish_frame(1'b1);
      // read header with a wrong count, mode drops to status mid-frame,
      // the next word closes the frame and the count error beats the bad crc
      set_frame_mode(1'b1);
      send_header(FLAW_COUNT, 8, FILL_RANDOM, 1'b0);
      set_frame_mode(1'b0);
      finish_frame(1'b1);
   endtask

   task automatic run_random();
      logic           m;
      int             start;
      int             roll;
      frame_flaw_type flaw;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         m = (phase % 3 == 1);
         if (phase == 7) begin
            // header placed in status mode, then a few words placed as read-mode
            // samples, left open for the next mark to restart
            flaw = pick_flaw();
            send_header(flaw, 8, FILL_RANDOM, choose_mark());
            set_frame_mode(1'b1);
            send_samples($urandom_range(1, 6));
         end else begin
            set_frame_mode(m);
         end
         // a read frame left past its header ends on the first status-mode word
         if (!m && needs_close) begin
            finish_frame($urandom_range(0, 1) == 1);
            needs_close = 1'b0;
         end
         if (phase == 1) begin
            send_header(FLAW_NONE, 8, FILL_RANDOM, choose_mark());
            send_samples(SAMPLE_COUNT);
            finish_frame(1'b0);
         end
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (!m) begin
               if (roll < 80) begin
                  flaw = pick_flaw();
                  send_header(flaw, 8, FILL_RANDOM, choose_mark());
                  finish_frame(flaw == FLAW_CRC);
               end else if (roll < 90) begin
                  send_header(pick_flaw(), $urandom_range(1, 7), FILL_RANDOM, choose_mark());
               end else begin
                  send_noise($urandom_range(1, 6));
               end
            end else begin
               // read frames too long to finish here, restarted by the next mark
               if (roll < 70) begin
                  send_header(pick_flaw(), 8, FILL_RANDOM, choose_mark());
                  send_samples($urandom_range(0, 12));
               end else if (roll < 85) begin
                  send_header(pick_flaw(), $urandom_range(1, 7), FILL_RANDOM, choose_mark());
               end else begin
                  send_noise($urandom_range(1, 6));
               end
            end
         end
         if (m) begin
            send_header(pick_flaw(), 8, FILL_RANDOM, choose_mark());
            send_samples($urandom_range(0, 6));
            needs_close = 1'b1;
         end
      end
   endtask

   initial begin
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
